### design/scfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scfd_pkg
// Shared constants and controller/datapath interface types for the frame
// dropping send queue.
// ----------------------------------------------------------------------------
package scfd_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int MIN_FILL    = 5;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int TIME_W  = 48;
    localparam int META_W  = 20;
    localparam int ENTRY_W = TIME_W + META_W;
    localparam int THR_W   = 24;

    localparam logic [THR_W:0] P_MARGIN_USEC = 25'd200000;
    localparam logic [THR_W-1:0] BFRAME_RESET = 24'd700000;
    localparam logic [THR_W-1:0] PFRAME_RESET = 24'd900000;

    localparam logic [1:0] KIND_VIDEO = 2'd0;
    localparam logic [1:0] KIND_AUDIO = 2'd1;
    localparam logic [1:0] KIND_POP   = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    localparam logic [1:0] REG_BFRAME = 2'd0;
    localparam logic [1:0] REG_PFRAME = 2'd1;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 160;

    typedef struct packed {
        logic load;        // capture the input transaction
        logic scan_init;   // start a span check
        logic scan_run;    // walk the queue looking for a non-key video entry
        logic span_zero;   // too few entries: clear the reported span
        logic span_update; // publish the measured span
        logic purge_init;
        logic purge_run;
        logic purge_commit;
        logic pop_read;    // fetch the head entry
        logic finish;      // perform the operation and load the result register
        logic level_hi;    // 0: b-frame check (level 2), 1: p-frame check (level 3)
    } scfd_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       fill_low;
        logic       scan_done;
        logic       found;
        logic       exceed;
        logic       purge_done;
        logic       out_free;
    } scfd_status_t;

endpackage : scfd_pkg
`default_nettype wire

### design/stream_congestion_frame_dropper_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stream_congestion_frame_dropper_top
// Send queue of packet descriptors with congestion-driven video frame dropping.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one operation per transaction; s_tuser carries the kind
//   (push video, push audio, pop, clear), s_tdata the packet descriptor.
//   m_ channel: exactly one result per operation, in order.
//   cfg channel: threshold writes (index 0 b-frame, 1 p-frame), always ready;
//   write only while no operation is in flight.
// Timing: one operation at a time. Audio push and clear go straight to the result
//   stage, pop reads the head entry first. A video push runs two checks; each
//   clears the span below five entries, else walks the queue to the first
//   non-key video entry, followed by a compaction pass over the entry memory
//   when the span exceeds the threshold.
// The result sits in an output register: a stalled receiver does not block
//   acceptance of the next transaction, only the loading of its result.
// Reset (synchronous, aresetn low) empties the queue, zeroes counters and
//   restores the default thresholds; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module stream_congestion_frame_dropper_top import scfd_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // decode time[47:0], drop level[49:48], keyframe[50], payload_tag[66:51], zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // kind[1:0]
    input  wire logic [1:0]             s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // accepted[0], pop_valid[1], pop_is_video[2], pop_keyframe[3], pop_priority[5:4],
    // popped decode time[53:6], pop_tag[69:54], dropped_total[101:70],
    // queue_count[108:102], buffer_span_usec[156:109], congested[157], overflow[158],
    // zero pad
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [THR_W-1:0]       cfg_data
);

    scfd_cmd_t    cmd;
    scfd_status_t status;

    assign cfg_ready = 1'b1;

    scfd_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    scfd_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule : stream_congestion_frame_dropper_top
`default_nettype wire

### design/scfd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scfd_datapath
// Entry memory, queue pointers, counters, span measurement and result register.
// ----------------------------------------------------------------------------
module scfd_datapath import scfd_pkg::*; (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire scfd_cmd_t               cmd,
    output scfd_status_t                 status,
    input  wire logic [1:0]              s_tuser,
    input  wire logic [IN_TDATA_W-1:0]   s_tdata,
    input  wire logic                    cfg_valid,
    input  wire logic [1:0]              cfg_index,
    input  wire logic [THR_W-1:0]        cfg_data,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [OUT_TDATA_W-1:0]       m_tdata
);

    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];

    logic [1:0]         kind_reg;
    logic [TIME_W-1:0]  dts_reg;
    logic [1:0]         prio_reg;
    logic               key_reg;
    logic [15:0]        tag_reg;

    logic [THR_W-1:0]   bthr_reg, pthr_reg;
    logic [THR_W:0]     thr_reg;
    logic [ADDR_W-1:0]  head_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [1:0]         minp_reg;
    logic [TIME_W-1:0]  lvt_reg;
    logic [31:0]        dropped_reg;
    logic [TIME_W-1:0]  span_out_reg;

    logic [CNT_W-1:0]   rd_idx_reg, kept_reg, removed_reg;
    logic               rd_vld_reg, found_reg;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [TIME_W:0]    span_reg;

    logic                  out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_reg;

    logic               issue;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [THR_W:0]     alt_thr;
    logic [1:0]         level;
    logic               rd_video, rd_key, keep;
    logic [1:0]         rd_prio;
    logic [32:0]        drop_sum;

    assign level    = cmd.level_hi ? 2'd3 : 2'd2;
    assign alt_thr  = {1'b0, bthr_reg} + P_MARGIN_USEC;
    assign rd_video = rd_data_reg[19];
    assign rd_key   = rd_data_reg[18];
    assign rd_prio  = rd_data_reg[17:16];
    assign keep     = !rd_video || (rd_prio >= level);
    assign drop_sum = {1'b0, dropped_reg} + {{(33-CNT_W){1'b0}}, removed_reg};

    always_comb begin
        issue   = (cmd.scan_run && !found_reg && rd_idx_reg < count_reg)
                  || (cmd.purge_run && rd_idx_reg < count_reg);
        rd_addr = cmd.pop_read ? head_reg : head_reg + rd_idx_reg[ADDR_W-1:0];
        wr_en   = 1'b0;
        wr_addr = head_reg + count_reg[ADDR_W-1:0];
        wr_data = {dts_reg, (kind_reg == KIND_VIDEO), key_reg, prio_reg, tag_reg};
        if (cmd.purge_run && rd_vld_reg && keep) begin
            wr_en   = 1'b1;
            wr_addr = head_reg + kept_reg[ADDR_W-1:0];
            wr_data = rd_data_reg;
        end else if (cmd.finish && count_reg < CNT_W'(QUEUE_DEPTH)
                     && (kind_reg == KIND_AUDIO
                         || (kind_reg == KIND_VIDEO && prio_reg >= minp_reg))) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (issue || cmd.pop_read) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign status.kind       = kind_reg;
    assign status.fill_low   = count_reg < CNT_W'(MIN_FILL);
    assign status.scan_done  = found_reg || (rd_idx_reg == count_reg && !rd_vld_reg);
    assign status.found      = found_reg;
    assign status.exceed     = $signed(span_reg) > $signed({{(TIME_W-THR_W){1'b0}}, thr_reg});
    assign status.purge_done = rd_idx_reg == count_reg && !rd_vld_reg;
    assign status.out_free   = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= s_tuser;
            dts_reg  <= s_tdata[47:0];
            prio_reg <= s_tdata[49:48];
            key_reg  <= s_tdata[50];
            tag_reg  <= s_tdata[66:51];
        end
        if (cmd.scan_init) begin
            if (cmd.level_hi) begin
                thr_reg <= ({1'b0, pthr_reg} < alt_thr) ? alt_thr : {1'b0, pthr_reg};
            end else begin
                thr_reg <= {1'b0, bthr_reg};
            end
        end
        if (cmd.scan_run && rd_vld_reg && !found_reg && rd_video && !rd_key) begin
            span_reg <= $signed({lvt_reg[TIME_W-1], lvt_reg})
                      - $signed({rd_data_reg[ENTRY_W-1], rd_data_reg[ENTRY_W-1:META_W]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bthr_reg      <= BFRAME_RESET;
            pthr_reg      <= PFRAME_RESET;
            head_reg      <= '0;
            count_reg     <= '0;
            minp_reg      <= '0;
            lvt_reg       <= '0;
            dropped_reg   <= '0;
            span_out_reg  <= '0;
            rd_idx_reg    <= '0;
            kept_reg      <= '0;
            removed_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_BFRAME: bthr_reg <= cfg_data;
                    REG_PFRAME: pthr_reg <= cfg_data;
                    default: ;
                endcase
            end
            rd_vld_reg <= issue;
            if (issue) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            if (cmd.scan_init || cmd.purge_init) begin
                rd_idx_reg  <= '0;
                found_reg   <= 1'b0;
                kept_reg    <= '0;
                removed_reg <= '0;
            end
            if (cmd.scan_run && rd_vld_reg && rd_video && !rd_key) begin
                found_reg <= 1'b1;
            end
            if (cmd.span_zero) begin
                span_out_reg <= '0;
            end
            if (cmd.span_update) begin
                span_out_reg <= span_reg[TIME_W] ? '0 : span_reg[TIME_W-1:0];
            end
            if (cmd.purge_run && rd_vld_reg) begin
                if (keep) begin
                    kept_reg <= kept_reg + 1'b1;
                end else begin
                    removed_reg <= removed_reg + 1'b1;
                end
            end
            if (cmd.purge_commit) begin
                count_reg   <= kept_reg;
                if (minp_reg < level) begin
                    minp_reg <= level;
                end
                dropped_reg <= drop_sum[32] ? '1 : drop_sum[31:0];
            end

            if (out_valid_reg && m_tready && !cmd.finish) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.finish) begin
                logic [1:0]  f_minp;
                logic [31:0] f_dropped;
                logic [CNT_W-1:0] f_count;
                logic [ADDR_W-1:0] f_head;
                logic f_acc, f_ovf, f_pv, f_vid, f_key;
                logic [1:0] f_prio;
                logic [TIME_W-1:0] f_dts, f_span;
                logic [15:0] f_tag;

                f_minp    = minp_reg;
                f_dropped = dropped_reg;
                f_count   = count_reg;
                f_head    = head_reg;
                f_span    = span_out_reg;
                f_acc = 1'b0; f_ovf = 1'b0; f_pv = 1'b0; f_vid = 1'b0; f_key = 1'b0;
                f_prio = '0; f_dts = '0; f_tag = '0;
                unique case (kind_reg)
                    KIND_VIDEO: begin
                        if (prio_reg < minp_reg) begin
                            f_dropped = (&dropped_reg) ? dropped_reg : dropped_reg + 1'b1;
                        end else begin
                            f_minp = '0;
                            if (count_reg < CNT_W'(QUEUE_DEPTH)) begin
                                f_count = count_reg + 1'b1;
                                f_acc   = 1'b1;
                                lvt_reg <= dts_reg;
                            end else begin
                                f_ovf = 1'b1;
                            end
                        end
                    end
                    KIND_AUDIO: begin
                        if (count_reg < CNT_W'(QUEUE_DEPTH)) begin
                            f_count = count_reg + 1'b1;
                            f_acc   = 1'b1;
                        end else begin
                            f_ovf = 1'b1;
                        end
                    end
                    KIND_POP: begin
                        if (count_reg != '0) begin
                            f_pv    = 1'b1;
                            f_vid   = rd_data_reg[19];
                            f_key   = rd_data_reg[18];
                            f_prio  = rd_data_reg[17:16];
                            f_tag   = rd_data_reg[15:0];
                            f_dts   = rd_data_reg[ENTRY_W-1:META_W];
                            f_head  = head_reg + 1'b1;
                            f_count = count_reg - 1'b1;
                        end
                    end
                    KIND_CLEAR: begin
                        f_head    = '0;
                        f_count   = '0;
                        f_dropped = '0;
                        f_minp    = '0;
                        f_span    = '0;
                    end
                    default: ;
                endcase
                minp_reg      <= f_minp;
                dropped_reg   <= f_dropped;
                count_reg     <= f_count;
                head_reg      <= f_head;
                span_out_reg  <= f_span;
                out_valid_reg <= 1'b1;
                out_reg <= {1'b0, f_ovf, (f_minp != 2'd0), f_span, 7'(f_count),
                            f_dropped, f_tag, f_dts, f_prio, f_key, f_vid, f_pv, f_acc};
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");
    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten");
    a_count_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan_run || cmd.purge_run) |=> count_reg == $past(count_reg))
        else $error("count moved during a queue walk");
    a_kept_le_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.purge_run |-> kept_reg <= rd_idx_reg)
        else $error("compaction write overtook read");

endmodule : scfd_datapath
`default_nettype wire

### design/scfd_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scfd_controller
// Sequencer: accepts a transaction, runs both congestion checks for video,
// fetches the head for pops and hands the result to the output register.
// ----------------------------------------------------------------------------
module scfd_controller import scfd_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [1:0]   s_tuser,
    input  wire scfd_status_t status,
    output scfd_cmd_t         cmd
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_CHECK  = 8'b0000_0010,
        ST_SCAN   = 8'b0000_0100,
        ST_SPAN   = 8'b0000_1000,
        ST_PURGE  = 8'b0001_0000,
        ST_COMMIT = 8'b0010_0000,
        ST_POP    = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   lvl_reg, lvl_next;

    assign s_tready = state_reg == ST_IDLE;

    always_comb begin
        state_next   = state_reg;
        lvl_next     = lvl_reg;
        cmd          = '0;
        cmd.level_hi = lvl_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    lvl_next = 1'b0;
                    case (s_tuser)
                        KIND_VIDEO: state_next = ST_CHECK;
                        KIND_POP:   state_next = ST_POP;
                        default:    state_next = ST_FINISH;
                    endcase
                end
            end
            ST_CHECK: begin
                if (status.fill_low) begin
                    cmd.span_zero = 1'b1;
                    lvl_next      = 1'b1;
                    state_next    = lvl_reg ? ST_FINISH : ST_CHECK;
                end else begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_run = 1'b1;
                if (status.scan_done) begin
                    state_next = ST_SPAN;
                end
            end
            ST_SPAN: begin
                lvl_next   = 1'b1;
                state_next = lvl_reg ? ST_FINISH : ST_CHECK;
                if (status.found) begin
                    cmd.span_update = 1'b1;
                    if (status.exceed) begin
                        cmd.purge_init = 1'b1;
                        lvl_next       = lvl_reg;
                        state_next     = ST_PURGE;
                    end
                end
            end
            ST_PURGE: begin
                cmd.purge_run = 1'b1;
                if (status.purge_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.purge_commit = 1'b1;
                lvl_next         = 1'b1;
                state_next       = lvl_reg ? ST_FINISH : ST_CHECK;
            end
            ST_POP: begin
                cmd.pop_read = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            lvl_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            lvl_reg   <= lvl_next;
        end
    end

    a_purge_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PURGE && $past(state_reg) != ST_PURGE) |-> $past(state_reg) == ST_SPAN)
        else $error("purge entered without a span check");
    a_accept_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> cmd.load)
        else $error("accepted transaction not captured");
    a_one_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.scan_run && cmd.purge_run) && !(cmd.finish && cmd.purge_commit))
        else $error("conflicting datapath commands");

endmodule : scfd_controller
`default_nettype wire

### tb/sv/stream_congestion_frame_dropper_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_congestion_frame_dropper_top_tb
// Drives push, pop and clear transactions with random gaps on both streams,
// rewrites the thresholds between phases and checks every result against a
// cycle-free model of the send queue and its frame dropping.
// ----------------------------------------------------------------------------
module stream_congestion_frame_dropper_top_tb;
    import scfd_pkg::*;

    typedef struct packed {
        logic        overflow;
        logic        congested;
        logic [47:0] span;
        logic [6:0]  count;
        logic [31:0] dropped;
        logic [15:0] pop_tag;
        logic [47:0] pop_dts;
        logic [1:0]  pop_prio;
        logic        pop_key;
        logic        pop_video;
        logic        pop_valid;
        logic        accepted;
    } queue_result_t;

    class send_queue_scoreboard;
        logic [47:0]   slot_time [QUEUE_DEPTH];
        logic [19:0]   slot_meta [QUEUE_DEPTH]; // video, key, prio[1:0], tag[15:0]
        int            head;
        int            fill;
        int            min_level;
        longint        last_vts;
        longint        span_held;
        logic [31:0]   drops;
        longint        b_thr;
        longint        p_thr;
        queue_result_t pending_q[$];
        int            errors;

        function new();
            head = 0; fill = 0; min_level = 0; last_vts = 0; span_held = 0;
            drops = 0; b_thr = BFRAME_RESET; p_thr = PFRAME_RESET; errors = 0;
        endfunction

        function void set_threshold(logic [1:0] idx, logic [THR_W-1:0] v);
            if (idx == REG_BFRAME) b_thr = v;
            else if (idx == REG_PFRAME) p_thr = v;
        endfunction

        function int at(int i);
            return (head + i) % QUEUE_DEPTH;
        endfunction

        function longint sx(logic [47:0] v);
            return {{16{v[47]}}, v};
        endfunction

        function void add_drops(longint n);
            longint s;
            s = longint'(drops) + n;
            drops = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function void purge(int level);
            int kept, removed, s, d;
            kept = 0; removed = 0;
            for (int i = 0; i < fill; i++) begin
                s = at(i);
                if (!slot_meta[s][19] || slot_meta[s][17:16] >= level) begin
                    d = at(kept);
                    slot_time[d] = slot_time[s];
                    slot_meta[d] = slot_meta[s];
                    kept++;
                end else begin
                    removed++;
                end
            end
            fill = kept;
            if (min_level < level) min_level = level;
            add_drops(removed);
        endfunction

        function void span_check(longint thr, int level);
            longint sp;
            if (fill < MIN_FILL) begin
                span_held = 0;
                return;
            end
            for (int i = 0; i < fill; i++) begin
                if (slot_meta[at(i)][19] && !slot_meta[at(i)][18]) begin
                    sp = last_vts - sx(slot_time[at(i)]);
                    span_held = (sp < 0) ? 0 : sp;
                    if (sp > thr) purge(level);
                    return;
                end
            end
        endfunction

        function bit store(logic [47:0] t, logic [19:0] m);
            if (fill >= QUEUE_DEPTH) return 0;
            slot_time[at(fill)] = t;
            slot_meta[at(fill)] = m;
            fill++;
            return 1;
        endfunction

        function void note_operation(logic [1:0] kind, logic [47:0] dts, logic [1:0] prio,
                                     logic key, logic [15:0] tag);
            queue_result_t r;
            longint pt;
            r = '0;
            if (kind == KIND_VIDEO) begin
                pt = (p_thr < b_thr + 200000) ? b_thr + 200000 : p_thr;
                span_check(b_thr, 2);
                span_check(pt, 3);
                if (prio < min_level) begin
                    add_drops(1);
                end else begin
                    min_level = 0;
                    if (store(dts, {1'b1, key, prio, tag})) begin
                        last_vts = sx(dts);
                        r.accepted = 1;
                    end else begin
                        r.overflow = 1;
                    end
                end
            end else if (kind == KIND_AUDIO) begin
                if (store(dts, {1'b0, key, prio, tag})) r.accepted = 1;
                else r.overflow = 1;
            end else if (kind == KIND_POP) begin
                if (fill > 0) begin
                    r.pop_valid = 1;
                    r.pop_video = slot_meta[head][19];
                    r.pop_key   = slot_meta[head][18];
                    r.pop_prio  = slot_meta[head][17:16];
                    r.pop_tag   = slot_meta[head][15:0];
                    r.pop_dts   = slot_time[head];
                    head = (head + 1) % QUEUE_DEPTH;
                    fill--;
                end
            end else begin
                head = 0; fill = 0; drops = 0; min_level = 0; span_held = 0;
            end
            r.dropped   = drops;
            r.count     = fill[6:0];
            r.span      = span_held[47:0];
            r.congested = (min_level > 0);
            pending_q.insert(pending_q.size(), r);
        endfunction

        function void field(string name, logic [63:0] e, logic [63:0] a, ref bit bad);
            if (e !== a) begin
                if (errors < 10)
                    $display("mismatch %s: expected %0h actual %0h", name, e, a);
                bad = 1;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data);
            queue_result_t e, a;
            bit bad;
            bad = 0;
            a = data[$bits(queue_result_t)-1:0];
            if (pending_q.size() == 0) begin
                if (errors < 10) $display("result with no operation outstanding");
                errors++;
                return;
            end
            e = pending_q[0];
            pending_q.delete(0);
            field("accepted", e.accepted, a.accepted, bad);
            field("pop_valid", e.pop_valid, a.pop_valid, bad);
            field("pop_is_video", e.pop_video, a.pop_video, bad);
            field("pop_keyframe", e.pop_key, a.pop_key, bad);
            field("pop_priority", e.pop_prio, a.pop_prio, bad);
            field("pop_time", e.pop_dts, a.pop_dts, bad);
            field("pop_tag", e.pop_tag, a.pop_tag, bad);
            field("dropped_total", e.dropped, a.dropped, bad);
            field("queue_count", e.count, a.count, bad);
            field("buffer_span_usec", e.span, a.span, bad);
            field("congested", e.congested, a.congested, bad);
            field("overflow", e.overflow, a.overflow, bad);
            if (data[OUT_TDATA_W-1:$bits(queue_result_t)] !== '0) begin
                if (errors < 10) $display("mismatch: padding bits not zero");
                bad = 1;
            end
            if (bad) errors++;
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [1:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [1:0]             cfg_index;
    logic [THR_W-1:0]       cfg_data;

    send_queue_scoreboard sb;
    bit     no_gaps;
    bit     hold_request;
    int     hold_left;
    longint stream_dts;

    stream_congestion_frame_dropper_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial aclk = 0;
    always #4 aclk = ~aclk;

    initial begin
        #20ms;
        $display("stream_congestion_frame_dropper_top test failed");
        $finish;
    end

    // receiver: random back-pressure plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_request && hold_left == 0) begin
            hold_left <= 600;
            hold_request <= 0;
            m_tready <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 0;
        end else begin
            m_tready <= no_gaps || ($urandom_range(0, 99) >= 29);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    task automatic send_op(logic [1:0] kind, logic [47:0] dts, logic [1:0] prio,
                           logic key, logic [15:0] tag);
        @(negedge aclk);
        if (!no_gaps && $urandom_range(0, 99) < 29) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= kind;
        s_tdata  <= {5'd0, tag, key, prio, dts};
        do @(posedge aclk); while (!s_tready);
        sb.note_operation(kind, dts, prio, key, tag);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [THR_W-1:0] v);
        @(negedge aclk);
        s_tvalid  <= 0;
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_threshold(idx, v);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    // mostly a plausible stream with rising time stamps, some raw noise
    task automatic random_op(int pop_pct);
        int r;
        logic [1:0] kind;
        logic [47:0] d;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 15) begin
            d = 48'({$urandom, $urandom});
            send_op(r[1:0], d, 2'($urandom), 1'($urandom), 16'($urandom));
            return;
        end
        if (r < 2) kind = KIND_CLEAR;
        else if (r < 2 + pop_pct) kind = KIND_POP;
        else if (r < 2 + pop_pct + 20) kind = KIND_AUDIO;
        else kind = KIND_VIDEO;
        if ($urandom_range(0, 99) < 3) stream_dts -= $urandom_range(0, 2000000);
        else stream_dts += $urandom_range(0, 70000);
        send_op(kind, stream_dts[47:0], 2'($urandom), ($urandom_range(0, 9) == 0),
                16'($urandom));
    endtask

    initial begin
        logic [THR_W-1:0] b_set [6];
        logic [THR_W-1:0] p_set [6];
        int pop_set [6];
        int n;
        sb = new();
        aresetn = 0; s_tvalid = 0; s_tdata = '0; s_tuser = KIND_VIDEO; m_tready = 0;
        cfg_valid = 0; cfg_index = REG_BFRAME; cfg_data = '0;
        no_gaps = 0; hold_request = 0; hold_left = 0; stream_dts = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed part at reset thresholds
        send_op(KIND_POP, '0, 0, 0, 0);
        send_op(KIND_AUDIO, 48'h7FFF_FFFF_FFFF, 3, 1, 16'hFFFF);
        send_op(KIND_VIDEO, 48'h8000_0000_0000, 0, 0, 16'h0000);
        send_op(KIND_POP, '0, 0, 0, 0);
        send_op(KIND_POP, '0, 0, 0, 0);
        send_op(KIND_POP, '0, 0, 0, 0);
        send_op(KIND_VIDEO, 48'd0, 0, 1, 16'h1111);
        for (int i = 0; i < 5; i++)
            send_op(KIND_VIDEO, 48'd100 * (i + 1), i[1:0], 0, 16'(16'h2000 + i));
        send_op(KIND_VIDEO, 48'd1000000, 1, 0, 16'h3000);
        send_op(KIND_VIDEO, 48'd1100000, 1, 0, 16'h3001);
        send_op(KIND_VIDEO, 48'd1200000, 0, 0, 16'h3002);
        send_op(KIND_AUDIO, 48'd1200001, 0, 0, 16'h3003);
        send_op(KIND_VIDEO, 48'd3000000, 3, 0, 16'h3004);
        send_op(KIND_VIDEO, 48'd100, 3, 0, 16'h3005);
        send_op(KIND_VIDEO, 48'd50, 2, 0, 16'h3006);
        send_op(KIND_POP, '0, 0, 0, 0);
        send_op(KIND_CLEAR, '0, 0, 0, 0);
        send_op(KIND_POP, '0, 0, 0, 0);

        b_set = '{24'd700000, 24'd0, 24'd16000000, 24'd30000, 24'd16000000, 24'd0};
        p_set = '{24'd900000, 24'd0, 24'd16000000, 24'd250000, 24'd0, 24'd16000000};
        pop_set = '{30, 35, 12, 30, 25, 35};
        n = 0;
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            if (ph == 3) begin
                b_set[ph] = 24'($urandom_range(0, 400000));
                p_set[ph] = 24'($urandom_range(0, 16000000));
            end
            write_reg(REG_BFRAME, b_set[ph]);
            write_reg(REG_PFRAME, p_set[ph]);
            for (int i = 0; i < 250; i++) begin
                no_gaps = (n >= 300 && n < 450);
                if (n == 700) hold_request = 1;
                random_op(pop_set[ph]);
                n++;
            end
        end
        no_gaps = 0;
        drain();
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("stream_congestion_frame_dropper_top test passed");
        else
            $display("stream_congestion_frame_dropper_top test failed");
        $finish;
    end
endmodule
